### rtl/hcis_pkg.sv
// ----------------------------------------------------------------------------
// hcis_pkg: shared types and constants
// Field widths, command and status codes, controller states and the modulo
// unit result for the hash table block.
// ----------------------------------------------------------------------------
package hcis_pkg;

  localparam int KEY_W  = 31;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int BKT_W  = 4;
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0] NB_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FOUND    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CLEAR  = 6'b000010,
    ST_MOD    = 6'b000100,
    ST_INS_WR = 6'b001000,
    ST_SEARCH = 6'b010000,
    ST_RESP   = 6'b100000
  } state_t;

  typedef struct packed {
    logic             done;
    logic [CFG_W-1:0] rem;
  } mod_res_t;

endpackage

### rtl/hcis_ram.sv
// ----------------------------------------------------------------------------
// hcis_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module hcis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/hcis_mod_unit.sv
// ----------------------------------------------------------------------------
// hcis_mod_unit: iterative key modulo
// Restoring remainder, one key bit per cycle, MSB first. done pulses with
// the final remainder.
// ----------------------------------------------------------------------------
module hcis_mod_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [hcis_pkg::KEY_W-1:0]  dividend,
  input  logic [hcis_pkg::CFG_W-1:0]  divisor,
  output hcis_pkg::mod_res_t          res
);

  localparam int CNT_W = $clog2(hcis_pkg::KEY_W);

  logic                       run;
  logic                       done;
  logic [CNT_W-1:0]           cnt;
  logic [hcis_pkg::KEY_W-1:0] shift;
  logic [hcis_pkg::CFG_W-1:0] rem;
  logic [hcis_pkg::CFG_W-1:0] rem_next;
  logic [hcis_pkg::CFG_W:0]   trial;

  always_comb begin
    trial = {rem, shift[hcis_pkg::KEY_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = hcis_pkg::CFG_W'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[hcis_pkg::CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(hcis_pkg::KEY_W - 1);
      end else if (run) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift <= dividend;
      rem   <= '0;
    end else if (run) begin
      shift <= shift << 1;
      rem   <= rem_next;
    end
  end

  assign res = '{done: done, rem: rem};

endmodule

### rtl/hash_chain_insert_search_top.sv
// ----------------------------------------------------------------------------
// hash_chain_insert_search_top: hash table with bounded per-bucket chains
// Row RAM per bucket (fill count + key slots), iterative hash, row scan.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries cmd and key; output channel
//   (out_valid/out_stall) returns status and bucket, one beat per command.
//   cfg_we/cfg_wdata write num_buckets (clamped to 1..BUCKETS); write it
//   only while the block is idle.
//   One command at a time; in_stall is high until the command finishes.
//   Insert: the bit-serial modulo (31 steps), then one row read and one
//     row write-back (skipped when the row is full).
//   Search: up to num_buckets rows (clamped), one bucket row read per cycle,
//     all slots of the row compared at once; stops at the first hit.
//   Clear: one row's fill count zeroed per cycle.
//   Reset: a clearing pass over all BUCKETS rows runs first; in_stall stays high
//     until it finishes. num_buckets resets to 16.
//   The result sits in an output register; a stalled output beat holds and
//   the next command is still accepted, but its result waits until the
//   output register frees up.
// ----------------------------------------------------------------------------
module hash_chain_insert_search_top #(
  parameter int BUCKETS = 16,
  parameter int SLOTS   = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [hcis_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [hcis_pkg::CMD_W-1:0]   cmd,
  input  logic [hcis_pkg::KEY_W-1:0]   key,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hcis_pkg::STAT_W-1:0]  status,
  output logic [hcis_pkg::BKT_W-1:0]   bucket
);

  localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int FILL_W = $clog2(SLOTS + 1);
  localparam int KW     = hcis_pkg::KEY_W;
  localparam int NW     = hcis_pkg::CFG_W;
  localparam int ROW_W  = FILL_W + SLOTS * KW;

  hcis_pkg::state_t state;

  logic [NW-1:0]     num_buckets;
  logic [NW-1:0]     nb;
  logic [KW-1:0]     key_q;
  logic [NW-1:0]     bkt;
  logic [BW-1:0]     clr_addr;
  logic              clr_resp;
  logic [NW-1:0]     scan;
  logic [NW-1:0]     chk_bkt;
  logic              chk_valid;
  logic [hcis_pkg::STAT_W-1:0] res_status;
  logic [hcis_pkg::BKT_W-1:0]  res_bucket;

  logic              rd_en;
  logic [BW-1:0]     rd_addr;
  logic [ROW_W-1:0]  rd_data;
  logic              wr_en;
  logic [BW-1:0]     wr_addr;
  logic [ROW_W-1:0]  wr_data;
  logic [ROW_W-1:0]  new_row;
  logic [FILL_W-1:0] fill;
  logic              full;
  logic              hit;
  logic              last;
  logic              scan_ok;
  logic              mod_start;

  hcis_pkg::mod_res_t mod_res;

  // clamp the modulus to 1..BUCKETS
  always_comb begin
    if (num_buckets == '0) begin
      nb = NW'(1);
    end else if (32'(num_buckets) > BUCKETS) begin
      nb = NW'(BUCKETS);
    end else begin
      nb = num_buckets;
    end
  end

  assign in_stall  = (state != hcis_pkg::ST_IDLE);
  assign mod_start = (state == hcis_pkg::ST_IDLE) && in_valid &&
                     (cmd == hcis_pkg::CMD_INSERT);

  hcis_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (key),
    .divisor  (nb),
    .res      (mod_res)
  );

  // row decode: fill count on top, slot s at bits [s*KW +: KW]
  always_comb begin
    fill    = rd_data[ROW_W-1 -: FILL_W];
    full    = (fill >= FILL_W'(SLOTS));
    hit     = 1'b0;
    new_row = rd_data;
    for (int s = 0; s < SLOTS; s++) begin
      if ((FILL_W'(s) < fill) && (rd_data[s*KW +: KW] == key_q)) begin
        hit = 1'b1;
      end
      if (FILL_W'(s) == fill) begin
        new_row[s*KW +: KW] = key_q;
      end
    end
    new_row[ROW_W-1 -: FILL_W] = fill + FILL_W'(1);
  end

  assign last    = (chk_bkt == nb - NW'(1));
  assign scan_ok = (scan < nb);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = new_row;
    case (state)
      hcis_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      hcis_pkg::ST_MOD: begin
        rd_en   = mod_res.done;
        rd_addr = BW'(mod_res.rem);
      end
      hcis_pkg::ST_INS_WR: begin
        wr_en   = !full;
        wr_addr = BW'(bkt);
      end
      hcis_pkg::ST_SEARCH: begin
        rd_en   = !(chk_valid && (hit || last)) && scan_ok;
        rd_addr = BW'(scan);
      end
      default: begin
      end
    endcase
  end

  hcis_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_rows (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      num_buckets <= hcis_pkg::NB_RESET;
      state       <= hcis_pkg::ST_CLEAR;
      clr_addr    <= '0;
      clr_resp    <= 1'b0;
      scan        <= '0;
      chk_valid   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_buckets <= cfg_wdata;
      end
      // ST_RESP loads the next beat itself
      if (out_valid && !out_stall && (state != hcis_pkg::ST_RESP)) begin
        out_valid <= 1'b0;
      end
      case (state)
        hcis_pkg::ST_IDLE: begin
          if (in_valid) begin
            key_q <= key;
            case (cmd)
              hcis_pkg::CMD_INSERT: begin
                state <= hcis_pkg::ST_MOD;
              end
              hcis_pkg::CMD_SEARCH: begin
                scan      <= '0;
                chk_valid <= 1'b0;
                state     <= hcis_pkg::ST_SEARCH;
              end
              hcis_pkg::CMD_CLEAR: begin
                clr_addr <= '0;
                clr_resp <= 1'b1;
                state    <= hcis_pkg::ST_CLEAR;
              end
              default: begin
                res_status <= hcis_pkg::STAT_OK;
                res_bucket <= '0;
                state      <= hcis_pkg::ST_RESP;
              end
            endcase
          end
        end
        hcis_pkg::ST_CLEAR: begin
          if (clr_addr == BW'(BUCKETS - 1)) begin
            res_status <= hcis_pkg::STAT_OK;
            res_bucket <= '0;
            state      <= clr_resp ? hcis_pkg::ST_RESP : hcis_pkg::ST_IDLE;
          end else begin
            clr_addr <= clr_addr + BW'(1);
          end
        end
        hcis_pkg::ST_MOD: begin
          if (mod_res.done) begin
            bkt   <= mod_res.rem;
            state <= hcis_pkg::ST_INS_WR;
          end
        end
        hcis_pkg::ST_INS_WR: begin
          res_status <= full ? hcis_pkg::STAT_FULL : hcis_pkg::STAT_OK;
          res_bucket <= hcis_pkg::BKT_W'(bkt);
          state      <= hcis_pkg::ST_RESP;
        end
        hcis_pkg::ST_SEARCH: begin
          if (chk_valid && hit) begin
            res_status <= hcis_pkg::STAT_FOUND;
            res_bucket <= hcis_pkg::BKT_W'(chk_bkt);
            state      <= hcis_pkg::ST_RESP;
          end else if (chk_valid && last) begin
            res_status <= hcis_pkg::STAT_NOTFOUND;
            res_bucket <= '0;
            state      <= hcis_pkg::ST_RESP;
          end else begin
            // data for chk_bkt lands next cycle
            chk_valid <= scan_ok;
            chk_bkt   <= scan;
            if (scan_ok) begin
              scan <= scan + NW'(1);
            end
          end
        end
        hcis_pkg::ST_RESP: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status    <= res_status;
            bucket    <= res_bucket;
            state     <= hcis_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= hcis_pkg::ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    state == hcis_pkg::ST_INS_WR |-> fill <= FILL_W'(SLOTS))
    else $error("row fill count above slot count");

  a_mod_in_state: assert property (@(posedge clk) disable iff (rst)
    mod_res.done |-> state == hcis_pkg::ST_MOD)
    else $error("modulo result outside insert");

  a_mod_range: assert property (@(posedge clk) disable iff (rst)
    mod_res.done |-> mod_res.rem < nb)
    else $error("hash bucket out of range");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != hcis_pkg::ST_IDLE)
    else $error("accepted beat not started");

  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    state == hcis_pkg::ST_RESP && out_valid && out_stall |=>
      state == hcis_pkg::ST_RESP)
    else $error("result dropped while output stalled");
`endif

endmodule
